[sv/renko_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// renko_pkg
// Shared types and constants of the Renko brick generator.
// ----------------------------------------------------------------------------
package renko_pkg;

   localparam int PRICE_W    = 32;
   localparam int STAMP_W    = 48;
   localparam int SIZE_W     = 32;
   localparam int LEVEL_W    = 33;
   localparam int ALU_W      = LEVEL_W + 1;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 32'd100;

   typedef struct packed {
      logic [PRICE_W-1:0] price;
      logic [STAMP_W-1:0] stamp;
   } req_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] brick_open;
      logic [LEVEL_W-1:0] brick_close;
      logic               rising;
      logic [STAMP_W-1:0] brick_stamp;
      logic               last_of_run;
      logic               truncated;
   } rsp_type;

   typedef struct packed {
      logic sub;
   } alu_ctl_type;

endpackage

[sv/renko_alu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// renko_alu
// Shared add/subtract unit used by every busy state of the sequencer.
// ----------------------------------------------------------------------------
module renko_alu
   import renko_pkg::*;
(
   input  alu_ctl_type      ctl,
   input  logic [ALU_W-1:0] op_a,
   input  logic [ALU_W-1:0] op_b,
   output logic [ALU_W-1:0] result
);

   assign result = ctl.sub ? (op_a - op_b) : (op_a + op_b);

endmodule

[sv/renko_brick_generator_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// renko_brick_generator_unit
// Turns a price stream into fixed-height Renko bricks.
//
// req_*  : one beat per price (price, stamp). req_ready is high only while
//          the sequencer is idle; one price is worked on at a time.
// rsp_*  : one beat per brick, held in an output register until taken.
// csr_*  : brick size write, always ready; write only while idle, and
//          reset afterwards if the size changes.
// Steps  : a price that makes no brick goes through accept and compare.
//          The first price after reset goes through accept, 33 divide
//          steps and level update. A price that makes k bricks goes
//          through accept, compare, operand setup, 33 restoring divide
//          steps, level update, then one brick per cycle while the output
//          is not stalled. The divider is bit-serial on the shared adder.
// Stall  : while rsp_ready is low the current brick holds and brick output
//          pauses; the next price is not taken before its bricks are loaded.
// Reset  : synchronous; clears the level, the anchor flag and the output
//          valid flag, and sets the brick size to 100.
// ----------------------------------------------------------------------------
module renko_brick_generator_unit
   import renko_pkg::*;
#(
   parameter int PRICE_BITS = 32,
   parameter int MAX_BRICKS = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [SIZE_W-1:0] csr_wdata
);

   localparam int CW     = $clog2(MAX_BRICKS + 1);
   localparam int DIV_W  = LEVEL_W;
   localparam int STEP_W = $clog2(DIV_W);
   localparam logic [PRICE_W-1:0] PRICE_MASK =
      (PRICE_BITS >= PRICE_W) ? {PRICE_W{1'b1}} : PRICE_W'((64'd1 << PRICE_BITS) - 64'd1);
   localparam logic [DIV_W-1:0]  MAX_Q     = DIV_W'(MAX_BRICKS);
   localparam logic [CW-1:0]     MAX_C     = CW'(MAX_BRICKS);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_W - 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_PREP  = 3'd2;
   localparam logic [2:0] S_DIV   = 3'd3;
   localparam logic [2:0] S_FIX   = 3'd4;
   localparam logic [2:0] S_EMIT  = 3'd5;

   logic [2:0]         state_ff, state_in;
   logic [SIZE_W-1:0]  csr_size_ff, csr_size_in;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic               anch_ff, anch_in;
   logic               first_ff, first_in;
   logic               up_ff, up_in;
   logic [PRICE_W-1:0] price_ff, price_in;
   logic [STAMP_W-1:0] stamp_ff, stamp_in;
   logic [SIZE_W-1:0]  size_ff, size_in;
   logic [DIV_W-1:0]   quo_ff, quo_in;
   logic [SIZE_W-1:0]  rem_ff, rem_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [LEVEL_W-1:0] open_ff, open_in;
   logic [CW-1:0]      emit_ff, emit_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               trunc_ff, trunc_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   alu_ctl_type        alu_ctl;
   logic [ALU_W-1:0]   alu_a, alu_b, alu_res;
   logic [ALU_W-1:0]   price_plus;
   logic               up_hit, dn_hit, div_ge, load, last;

   renko_alu u_alu (
      .ctl    (alu_ctl),
      .op_a   (alu_a),
      .op_b   (alu_b),
      .result (alu_res)
   );

   always_comb begin
      alu_ctl.sub = 1'b0;
      alu_a       = '0;
      alu_b       = '0;
      unique case (state_ff)
         S_CHECK: begin
            alu_a = ALU_W'(level_ff);
            alu_b = ALU_W'(size_ff);
         end
         S_PREP: begin
            alu_ctl.sub = 1'b1;
            alu_a = up_ff ? ALU_W'(price_ff) : ALU_W'(level_ff);
            alu_b = up_ff ? ALU_W'(level_ff) : ALU_W'(price_ff);
         end
         S_DIV: begin
            alu_ctl.sub = 1'b1;
            alu_a = ALU_W'({rem_ff, quo_ff[DIV_W-1]});
            alu_b = ALU_W'(size_ff);
         end
         S_FIX: begin
            alu_ctl.sub = up_ff;
            alu_a = ALU_W'(price_ff);
            alu_b = ALU_W'(rem_ff);
         end
         S_EMIT: begin
            alu_ctl.sub = !up_ff;
            alu_a = ALU_W'(open_ff);
            alu_b = ALU_W'(size_ff);
         end
         default: begin
            alu_ctl.sub = 1'b0;
         end
      endcase
   end

   assign price_plus = ALU_W'(price_ff) + ALU_W'(size_ff);
   assign up_hit     = ALU_W'(price_ff) >= alu_res;
   assign dn_hit     = price_plus <= ALU_W'(level_ff);
   assign div_ge     = !alu_res[ALU_W-1];
   assign load       = !rsp_valid_ff || rsp_ready;
   assign last       = cnt_ff == emit_ff - CW'(1);

   always_comb begin
      state_in     = state_ff;
      csr_size_in  = csr_size_ff;
      level_in     = level_ff;
      anch_in      = anch_ff;
      first_in     = first_ff;
      up_in        = up_ff;
      price_in     = price_ff;
      stamp_in     = stamp_ff;
      size_in      = size_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      open_in      = open_ff;
      emit_in      = emit_ff;
      cnt_in       = cnt_ff;
      trunc_in     = trunc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;

      if (csr_valid) begin
         csr_size_in = csr_wdata;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               price_in = req_data.price & PRICE_MASK;
               stamp_in = req_data.stamp;
               size_in  = (csr_size_ff == '0) ? SIZE_W'(1) : csr_size_ff;
               first_in = !anch_ff;
               up_in    = 1'b1;
               quo_in   = DIV_W'(req_data.price & PRICE_MASK);
               rem_in   = '0;
               step_in  = '0;
               state_in = anch_ff ? S_CHECK : S_DIV;
            end
         end
         S_CHECK: begin
            up_in = up_hit;
            if (up_hit || dn_hit) begin
               state_in = S_PREP;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_PREP: begin
            quo_in   = alu_res[DIV_W-1:0];
            rem_in   = '0;
            step_in  = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            rem_in  = div_ge ? alu_res[SIZE_W-1:0] : {rem_ff[SIZE_W-2:0], quo_ff[DIV_W-1]};
            quo_in  = {quo_ff[DIV_W-2:0], div_ge};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == LAST_STEP) begin
               state_in = S_FIX;
            end
         end
         S_FIX: begin
            level_in = alu_res[LEVEL_W-1:0];
            anch_in  = 1'b1;
            open_in  = level_ff;
            cnt_in   = '0;
            trunc_in = quo_ff > MAX_Q;
            emit_in  = (quo_ff > MAX_Q) ? MAX_C : quo_ff[CW-1:0];
            state_in = first_ff ? S_IDLE : S_EMIT;
         end
         S_EMIT: begin
            if (load) begin
               rsp_valid_in       = 1'b1;
               rsp_in.brick_open  = open_ff;
               rsp_in.brick_close = alu_res[LEVEL_W-1:0];
               rsp_in.rising      = up_ff;
               rsp_in.brick_stamp = stamp_ff;
               rsp_in.last_of_run = last;
               rsp_in.truncated   = last && trunc_ff;
               open_in            = alu_res[LEVEL_W-1:0];
               cnt_in             = cnt_ff + CW'(1);
               if (last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         csr_size_ff  <= SIZE_RESET;
         level_ff     <= '0;
         anch_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         csr_size_ff  <= csr_size_in;
         level_ff     <= level_in;
         anch_ff      <= anch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff <= first_in;
      up_ff    <= up_in;
      price_ff <= price_in;
      stamp_ff <= stamp_in;
      size_ff  <= size_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      step_ff  <= step_in;
      open_ff  <= open_in;
      emit_ff  <= emit_in;
      cnt_ff   <= cnt_in;
      trunc_ff <= trunc_in;
      rsp_ff   <= rsp_in;
   end

   assign req_ready = state_ff == S_IDLE;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[sv/renko_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// renko_checker
// Port-level checks of the brick generator, bound to the top level.
// ----------------------------------------------------------------------------
module renko_checker
   import renko_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("brick beat changed while stalled");

   a_trunc_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.truncated |-> rsp_data.last_of_run)
      else $error("truncated flag on a brick that is not last");

   a_direction: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.rising ? (rsp_data.brick_close > rsp_data.brick_open)
                                     : (rsp_data.brick_close < rsp_data.brick_open)))
      else $error("brick close on wrong side of open");

   a_run_chain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.last_of_run |=>
         rsp_valid && rsp_data.brick_open == $past(rsp_data.brick_close))
      else $error("bricks of one run not contiguous");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("brick beat valid after reset");

endmodule

bind renko_brick_generator_unit renko_checker u_renko_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

[tb/renko_brick_generator_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// renko_brick_generator_unit_tb
// Self-checking bench for the Renko brick generator.
//
// A queue of price beats feeds a valid/ready driver. A clocked monitor keeps
// its own copy of the brick level and the anchor flag. For every accepted
// price it builds the bricks it should cause, and it checks each returned
// brick field by field against the oldest one waiting. A directed run covers
// the anchor, the boundaries around one brick, the floor at zero, exactly
// MAX_BRICKS bricks and truncation. Random random-walk prices follow under
// several brick sizes, zero and all-ones among them, with random idle bursts
// on the price and brick channels.
// ----------------------------------------------------------------------------
module renko_brick_generator_unit_tb;
   import renko_pkg::*;

   localparam int  BRICK_LIMIT    = 64;
   localparam int  SETTLE_CYCLES  = 64;
   localparam int  WATCHDOG_LIMIT = 1000;
   localparam logic [SIZE_W-1:0] SIZE_MAX = '1;
   localparam logic [PRICE_W-1:0] PRICE_MAX = '1;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   req_type           req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rsp_type           rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [SIZE_W-1:0] csr_wdata = '0;

   req_type price_q[$];
   rsp_type brick_q[$];

   logic [SIZE_W-1:0]  brick_size = SIZE_RESET;
   logic [LEVEL_W-1:0] brick_level = '0;
   bit                 anchored = 1'b0;

   logic [SIZE_W-1:0] cur_size = SIZE_RESET;
   longint            walk_price = 0;
   int                stall_pct = 20;
   int                req_gap = 0;
   int                rsp_hold = 0;
   int                idle_cycles = 0;
   int                mismatch_count = 0;

   renko_brick_generator_unit #(
      .PRICE_BITS(PRICE_W),
      .MAX_BRICKS(BRICK_LIMIT)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   // Moves the level for one price and queues the bricks it should cause.
   task automatic advance_level(input req_type beat);
      logic [63:0] px;
      logic [63:0] sz;
      logic [63:0] lv;
      logic [63:0] n;
      logic [63:0] emit;
      logic [63:0] open_lvl;
      bit          up;
      rsp_type     b;
      px = 64'(beat.price);
      sz = (brick_size == '0) ? 64'd1 : 64'(brick_size);
      lv = 64'(brick_level);
      n  = 0;
      up = 1'b0;
      if (!anchored) begin
         brick_level = LEVEL_W'((px / sz) * sz);
         anchored    = 1'b1;
         return;
      end
      if (px >= lv + sz) begin
         up = 1'b1;
         n  = (px - lv) / sz;
      end else if (lv >= sz && px <= lv - sz) begin
         n = (lv - px) / sz;
      end
      if (n == 0)
         return;
      emit = (n > BRICK_LIMIT) ? 64'(BRICK_LIMIT) : n;
      for (longint k = 0; k < emit; k++) begin
         open_lvl      = up ? lv + k * sz : lv - k * sz;
         b.brick_open  = LEVEL_W'(open_lvl);
         b.brick_close = LEVEL_W'(up ? open_lvl + sz : open_lvl - sz);
         b.rising      = up;
         b.brick_stamp = beat.stamp;
         b.last_of_run = (k == emit - 1);
         b.truncated   = (k == emit - 1) && (n > emit);
         brick_q.push_back(b);
      end
      brick_level = LEVEL_W'(up ? lv + n * sz : lv - n * sz);
   endtask

   task automatic check_brick(input rsp_type got);
      rsp_type want;
      if (brick_q.size() == 0) begin
         report_mismatch("brick with none expected, open", 64'(got.brick_open), '0);
         return;
      end
      want = brick_q.pop_front();
      if (got.brick_open !== want.brick_open)
         report_mismatch("brick_open", 64'(got.brick_open), 64'(want.brick_open));
      if (got.brick_close !== want.brick_close)
         report_mismatch("brick_close", 64'(got.brick_close), 64'(want.brick_close));
      if (got.rising !== want.rising)
         report_mismatch("rising", 64'(got.rising), 64'(want.rising));
      if (got.brick_stamp !== want.brick_stamp)
         report_mismatch("brick_stamp", 64'(got.brick_stamp), 64'(want.brick_stamp));
      if (got.last_of_run !== want.last_of_run)
         report_mismatch("last_of_run", 64'(got.last_of_run), 64'(want.last_of_run));
      if (got.truncated !== want.truncated)
         report_mismatch("truncated", 64'(got.truncated), 64'(want.truncated));
   endtask

   // price driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (price_q.size() > 0 && $urandom_range(0, 99) < stall_pct) begin
            req_gap = $urandom_range(0, 8);
            req_valid <= 1'b0;
         end else if (price_q.size() > 0) begin
            req_valid <= 1'b1;
            req_data  <= price_q.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // brick sink
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 99) < stall_pct) begin
         rsp_hold = $urandom_range(0, 8);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // monitor and watchdog
   always @(posedge clock) begin
      bit moved;
      moved = 1'b0;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            brick_size = csr_wdata;
            moved = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            check_brick(rsp_data);
            moved = 1'b1;
         end
         if (req_valid && req_ready) begin
            advance_level(req_data);
            moved = 1'b1;
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   task automatic queue_price(input logic [PRICE_W-1:0] p, input logic [STAMP_W-1:0] s);
      req_type beat;
      beat.price = p;
      beat.stamp = s;
      price_q.push_back(beat);
   endtask

   task automatic wait_drained();
      while (price_q.size() > 0 || req_valid || brick_q.size() > 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_size(input logic [SIZE_W-1:0] v);
      wait_drained();
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_size = v;
   endtask

   // Random walk around the last price, mostly within three bricks, with
   // occasional jumps to anywhere and to both ends of the range.
   task automatic queue_walk(input int count);
      longint unsigned sz;
      longint unsigned spread;
      longint unsigned step;
      int              r;
      sz     = (cur_size == '0) ? 1 : longint'(cur_size);
      spread = 3 * sz;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 80) begin
            step = rand64() % (spread + 1);
            if ($urandom_range(0, 1))
               walk_price = walk_price + longint'(step);
            else
               walk_price = walk_price - longint'(step);
         end else if (r < 90) begin
            walk_price = longint'($urandom);
         end else if (r < 95) begin
            walk_price = 0;
         end else begin
            walk_price = longint'(PRICE_MAX);
         end
         if (walk_price < 0)
            walk_price = 0;
         if (walk_price > longint'(PRICE_MAX))
            walk_price = longint'(PRICE_MAX);
         queue_price(PRICE_W'(walk_price), STAMP_W'(rand64()));
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // default brick of 100
      queue_price(32'd12345, '0);
      queue_price(32'd12399, STAMP_W'(rand64()));
      queue_price(32'd12400, STAMP_W'(rand64()));
      queue_price(32'd12699, '1);
      queue_price(32'd12501, STAMP_W'(rand64()));
      queue_price(32'd12500, STAMP_W'(rand64()));
      queue_price(32'd12201, STAMP_W'(rand64()));
      queue_price(32'd0, STAMP_W'(rand64()));
      queue_price(32'd99, STAMP_W'(rand64()));
      queue_price(32'd100, STAMP_W'(rand64()));
      queue_price(32'd50, STAMP_W'(rand64()));
      queue_price(32'd0, STAMP_W'(rand64()));
      queue_price(32'd6400, STAMP_W'(rand64()));
      queue_price(32'd0, STAMP_W'(rand64()));
      queue_price(32'd6500, STAMP_W'(rand64()));
      queue_price(PRICE_MAX, STAMP_W'(rand64()));
      queue_price(32'd0, '1);

      write_size(32'd1);
      queue_price(32'd5, STAMP_W'(rand64()));
      queue_price(32'd3, STAMP_W'(rand64()));
      queue_price(32'd200, STAMP_W'(rand64()));
      queue_price(32'd0, STAMP_W'(rand64()));

      // zero size acts as one
      write_size(32'd0);
      queue_price(32'd1, STAMP_W'(rand64()));
      queue_price(32'd0, STAMP_W'(rand64()));

      write_size(SIZE_MAX);
      queue_price(PRICE_MAX, STAMP_W'(rand64()));
      queue_price(32'd0, STAMP_W'(rand64()));
      queue_price(PRICE_MAX - 1, STAMP_W'(rand64()));
      queue_price(PRICE_MAX, STAMP_W'(rand64()));
      walk_price = longint'(PRICE_MAX);

      stall_pct = 40;
      write_size(32'd1);
      queue_walk(70);

      stall_pct = $urandom_range(5, 40);
      write_size(32'd0);
      queue_walk(50);

      stall_pct = $urandom_range(5, 40);
      write_size(SIZE_MAX);
      queue_walk(30);

      stall_pct = $urandom_range(5, 40);
      write_size(SIZE_W'($urandom_range(2, 5000)));
      queue_walk(80);

      stall_pct = $urandom_range(5, 40);
      write_size(SIZE_W'($urandom));
      queue_walk(50);

      stall_pct = 25;
      write_size(SIZE_RESET);
      queue_walk(70);

      // no idling on either side for the tail
      wait_drained();
      stall_pct = 0;
      queue_walk(60);

      wait_drained();
      if (brick_q.size() > 0)
         report_mismatch("bricks never delivered", 64'(brick_q.size()), '0);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

[filelist.f]
sv/renko_pkg.sv
sv/renko_alu.sv
sv/renko_brick_generator_unit.sv
sv/renko_checker.sv
tb/renko_brick_generator_unit_tb.sv
